@@ sv/lscbe_pkg.sv @@
// Shared types, command codes and helper functions for the LED colour buffer engine.
package lscbe_pkg;

    localparam logic [3:0] OP_OFF       = 4'd0;
    localparam logic [3:0] OP_STRIP_SET = 4'd1;
    localparam logic [3:0] OP_STRIP_INC = 4'd2;
    localparam logic [3:0] OP_STRIP_DEC = 4'd3;
    localparam logic [3:0] OP_SET       = 4'd4;
    localparam logic [3:0] OP_INC       = 4'd5;
    localparam logic [3:0] OP_DEC       = 4'd6;
    localparam logic [3:0] OP_CHECK     = 4'd7;
    localparam logic [3:0] OP_SWAP      = 4'd8;
    localparam logic [3:0] OP_COPY      = 4'd9;
    localparam logic [3:0] OP_MOVE      = 4'd10;
    localparam logic [3:0] OP_ROTATE    = 4'd11;

    typedef enum logic [2:0] {
        M_ZERO,
        M_COLOR,
        M_INC,
        M_DEC,
        M_COPY,
        M_CHECK
    } mode_t;

    typedef enum logic [1:0] {
        D_NONE,
        D_STORE,
        D_SCR
    } dst_t;

    typedef enum logic [1:0] {
        B_ZERO,
        B_P1,
        B_P2
    } base_t;

    typedef struct packed {
        mode_t mode;
        logic  src_scr;
        base_t src_base;
        dst_t  dst;
        base_t dst_base;
    } desc_t;

    function automatic logic [23:0] adjust(input logic [23:0] c, input logic [23:0] d,
                                           input logic sub);
        logic [23:0] res;
        for (int k = 0; k < 3; k++)
        begin
            if (sub)
                res[k*8 +: 8] = c[k*8 +: 8] - d[k*8 +: 8];
            else
                res[k*8 +: 8] = c[k*8 +: 8] + d[k*8 +: 8];
        end
        return res;
    endfunction

    function automatic logic [1:0] op_phases(input logic [3:0] op);
        logic [1:0] n;
        case (op)
            OP_SWAP, OP_MOVE:   n = 2'd3;
            OP_COPY, OP_ROTATE: n = 2'd2;
            default:            n = 2'd1;
        endcase
        return n;
    endfunction

    // Per-phase walk description: where to read, what to write, and where.
    function automatic desc_t op_desc(input logic [3:0] op, input logic [1:0] ph);
        desc_t d;
        d = '{mode: M_COPY, src_scr: 1'b0, src_base: B_ZERO, dst: D_NONE, dst_base: B_ZERO};
        case (op)
            OP_OFF:       d = '{M_ZERO, 1'b0, B_ZERO, D_STORE, B_ZERO};
            OP_STRIP_SET: d = '{M_COLOR, 1'b0, B_ZERO, D_STORE, B_ZERO};
            OP_STRIP_INC: d = '{M_INC, 1'b0, B_ZERO, D_STORE, B_ZERO};
            OP_STRIP_DEC: d = '{M_DEC, 1'b0, B_ZERO, D_STORE, B_ZERO};
            OP_SET:       d = '{M_COLOR, 1'b0, B_P1, D_STORE, B_P1};
            OP_INC:       d = '{M_INC, 1'b0, B_P1, D_STORE, B_P1};
            OP_DEC:       d = '{M_DEC, 1'b0, B_P1, D_STORE, B_P1};
            OP_CHECK:     d = '{M_CHECK, 1'b0, B_P1, D_NONE, B_P1};
            OP_SWAP:
            begin
                if (ph == 2'd0)
                    d = '{M_COPY, 1'b0, B_P2, D_SCR, B_ZERO};
                else if (ph == 2'd1)
                    d = '{M_COPY, 1'b0, B_P1, D_STORE, B_P2};
                else
                    d = '{M_COPY, 1'b1, B_ZERO, D_STORE, B_P1};
            end
            OP_COPY, OP_MOVE:
            begin
                if (ph == 2'd0)
                    d = '{M_COPY, 1'b0, B_P1, D_SCR, B_ZERO};
                else if (ph == 2'd1)
                    d = '{M_COPY, 1'b1, B_ZERO, D_STORE, B_P2};
                else
                    d = '{M_ZERO, 1'b0, B_P1, D_STORE, B_P1};
            end
            OP_ROTATE:
            begin
                if (ph == 2'd0)
                    d = '{M_COPY, 1'b0, B_P1, D_SCR, B_ZERO};
                else
                    d = '{M_COPY, 1'b1, B_ZERO, D_STORE, B_P1};
            end
            default: d = '{M_COPY, 1'b0, B_ZERO, D_NONE, B_ZERO};
        endcase
        return d;
    endfunction

endpackage

@@ sv/lscbe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lscbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ sv/led_strip_color_buffer_engine.sv @@
// Top level: LED colour store, command sequencer and shared walk/remainder datapath.
//
// Commands arrive on the request channel (in_valid / in_stall) and each one
// yields exactly one result (out_valid / out_stall) carrying match and the
// echoed operation. led_count is written on the cfg channel (always ready);
// the user writes it only while the block is idle; the block does not enforce it.
// One request is worked at a time; in_stall is high from acceptance until the
// result has been loaded into the output register. Every walk visits each
// LED with a read state and then a write state (S_RD, S_WR) over one RAM port
// pair; a rotate first finds its start offset with a bitwise remainder step
// (S_DIV, then S_ADJ) before its walk.
// A finished result waits in the output register while the receiver stalls;
// a following request is already taken and held back only at its end.
// After reset the store is swept to zero, one LED per cycle, across all MAX_LEDS
// entries before the first request is taken.
module led_strip_color_buffer_engine #(
    parameter int MAX_LEDS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [8:0]  first_position,
    input  logic [9:0]  second_position,
    input  logic [15:0] count,
    input  logic        rotate_direction,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        match,
    output logic [3:0]  finished_operation
);
    import lscbe_pkg::*;

    localparam int AW = $clog2(MAX_LEDS);
    localparam int NW = $clog2(MAX_LEDS + 1);
    localparam int CW = (NW > 10) ? NW : 10;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_LEDS);
    localparam logic [AW-1:0] LAST_A = AW'(MAX_LEDS - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SETUP, S_DIV, S_ADJ, S_RD, S_WR, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [3:0]    op_reg, op_next;
    logic [8:0]    p1_reg, p1_next;
    logic [9:0]    p2_reg, p2_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic          dir_reg, dir_next;
    logic [23:0]   color_reg, color_next;
    logic [9:0]    led_count_reg, led_count_next;
    logic [NW-1:0] len_reg, len_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] j0_reg, j0_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic [1:0]    ph_reg, ph_next;
    logic [3:0]    div_reg, div_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    logic          match_reg, match_next;
    logic [3:0]    fin_op_reg, fin_op_next;

    desc_t         desc;
    logic [NW-1:0] src_base, dst_base, src_sum, dst_sum;
    logic [AW-1:0] raddr, store_waddr;
    logic          store_we, scr_we;
    logic [23:0]   store_wdata, wdata, store_rdata, scr_rdata, rdata;

    logic [CW-1:0] p1c, p2c, lcc, lim1, lim2, lim, end_c;
    logic [15:0]   copy_k;
    logic          p1_ok, p2_ok, rot_ok;
    logic [NW-1:0] setup_len;
    logic [NW:0]   shifted;

    function automatic logic [NW-1:0] base_val(input base_t b, input logic [8:0] p1,
                                               input logic [9:0] p2);
        logic [NW-1:0] v;
        case (b)
            B_P1:    v = NW'(p1);
            B_P2:    v = NW'(p2);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign match = match_reg;
    assign finished_operation = fin_op_reg;

    assign desc = op_desc(op_reg, ph_reg);
    assign src_base = base_val(desc.src_base, p1_reg, p2_reg);
    assign dst_base = base_val(desc.dst_base, p1_reg, p2_reg);
    assign src_sum = src_base + j_reg;
    assign dst_sum = dst_base + i_reg;
    assign raddr = src_sum[AW-1:0];
    assign rdata = desc.src_scr ? scr_rdata : store_rdata;

    always_comb
    begin
        case (desc.mode)
            M_ZERO:  wdata = '0;
            M_COLOR: wdata = color_reg;
            M_INC:   wdata = adjust(rdata, color_reg, 1'b0);
            M_DEC:   wdata = adjust(rdata, color_reg, 1'b1);
            default: wdata = rdata;
        endcase
    end

    assign store_we = (state_reg == S_CLR) || (state_reg == S_WR && desc.dst == D_STORE);
    assign store_waddr = (state_reg == S_CLR) ? clr_reg : dst_sum[AW-1:0];
    assign store_wdata = (state_reg == S_CLR) ? '0 : wdata;
    assign scr_we = (state_reg == S_WR) && (desc.dst == D_SCR);

    lscbe_ram #(.WIDTH(24), .DEPTH(MAX_LEDS)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (raddr),
        .rdata (store_rdata)
    );

    lscbe_ram #(.WIDTH(24), .DEPTH(MAX_LEDS)) u_scratch (
        .clk   (clk),
        .we    (scr_we),
        .waddr (dst_sum[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (scr_rdata)
    );

    // range clipping for the request held in the registers
    always_comb
    begin
        p1c = CW'(p1_reg);
        p2c = CW'(p2_reg);
        lcc = CW'(led_count_reg);
        p1_ok = p1c < MAX_C;
        p2_ok = p2c < MAX_C;
        lim1 = MAX_C - p1c;
        lim2 = MAX_C - p2c;
        lim = (lim1 < lim2) ? lim1 : lim2;
        copy_k = (cnt_reg > 16'(lim)) ? 16'(lim) : cnt_reg;
        end_c = p2_ok ? p2c : MAX_C;
        rot_ok = end_c > (p1c + CW'(1));
        unique case (op_reg) inside
            OP_OFF, OP_STRIP_SET, OP_STRIP_INC, OP_STRIP_DEC:
                setup_len = NW'((lcc < MAX_C) ? lcc : MAX_C);
            OP_SET, OP_INC, OP_DEC, OP_CHECK:
                setup_len = p1_ok ? NW'(1) : '0;
            OP_SWAP:
                setup_len = (p1_ok && p2_ok) ? NW'(1) : '0;
            OP_COPY, OP_MOVE:
                setup_len = (p1_ok && p2_ok) ? NW'(copy_k) : '0;
            OP_ROTATE:
                setup_len = rot_ok ? NW'(end_c - p1c) : '0;
            default:
                setup_len = '0;
        endcase
    end

    assign shifted = {rem_reg, cnt_reg[4'd15 - div_reg]};

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        cnt_next = cnt_reg;
        dir_next = dir_reg;
        color_next = color_reg;
        led_count_next = led_count_reg;
        len_next = len_reg;
        rem_next = rem_reg;
        j0_next = j0_reg;
        i_next = i_reg;
        j_next = j_reg;
        ph_next = ph_reg;
        div_next = div_reg;
        clr_next = clr_reg;
        hit_next = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        match_next = match_reg;
        fin_op_next = fin_op_reg;

        if (cfg_valid && cfg_ready)
            led_count_next = cfg_data;

        unique case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_A)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = operation;
                    p1_next = first_position;
                    p2_next = second_position;
                    cnt_next = count;
                    dir_next = rotate_direction;
                    color_next = {green, red, blue};
                    hit_next = 1'b0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                len_next = setup_len;
                i_next = '0;
                j_next = '0;
                j0_next = '0;
                ph_next = '0;
                rem_next = '0;
                div_next = '0;
                if (op_reg == OP_ROTATE && setup_len != '0)
                    state_next = S_DIV;
                else
                    state_next = S_RD;
            end
            S_DIV:
            begin
                if (shifted >= {1'b0, len_reg})
                    rem_next = NW'(shifted - {1'b0, len_reg});
                else
                    rem_next = NW'(shifted);
                div_next = div_reg + 4'd1;
                if (div_reg == 4'd15)
                    state_next = S_ADJ;
            end
            S_ADJ:
            begin
                j0_next = (dir_reg && rem_reg != '0) ? len_reg - rem_reg : rem_reg;
                j_next = j0_next;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (i_reg == len_reg)
                begin
                    if (ph_reg + 2'd1 < op_phases(op_reg))
                    begin
                        ph_next = ph_reg + 2'd1;
                        i_next = '0;
                        j_next = '0;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                    state_next = S_WR;
            end
            S_WR:
            begin
                if (desc.mode == M_CHECK)
                    hit_next = (rdata == color_reg);
                i_next = i_reg + NW'(1);
                j_next = (j_reg + NW'(1) == len_reg) ? '0 : j_reg + NW'(1);
                state_next = S_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    match_next = hit_reg;
                    fin_op_next = op_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            led_count_reg <= 10'd512;
            out_valid_reg <= 1'b0;
            ph_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            div_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            led_count_reg <= led_count_next;
            out_valid_reg <= out_valid_next;
            ph_reg <= ph_next;
            i_reg <= i_next;
            j_reg <= j_next;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        cnt_reg <= cnt_next;
        dir_reg <= dir_next;
        color_reg <= color_next;
        len_reg <= len_next;
        rem_reg <= rem_next;
        j0_reg <= j0_next;
        hit_reg <= hit_next;
        match_reg <= match_next;
        fin_op_reg <= fin_op_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while idle did not start work");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> (j_reg < len_reg && i_reg < len_reg))
        else $error("walk index past segment");

    a_no_write_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && op_reg == OP_CHECK) |-> (!store_we && !scr_we))
        else $error("check request wrote the store");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> (!out_valid && in_stall))
        else $error("activity during clearing sweep");
endmodule
